/* sv/sbbf_pkg.sv */
// ----------------------------------------------------------------------------
// sbbf_pkg
// Shared types and constants for the split block Bloom filter: salts,
// block geometry, command codes, register map and back-end state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbf_pkg;

    // block geometry
    localparam int WORDS      = 8;
    localparam int WORD_W     = 32;
    localparam int BLOCK_W    = WORDS * WORD_W;
    localparam int POS_W      = 5;
    localparam int POS_SHIFT  = 27;

    // sizing defaults
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int QUEUE_DEPTH    = 4;

    // configuration register
    localparam int CFG_W      = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] BLOCKS_RESET = 11'd1024;

    // register word index, taken from paddr[2]
    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    // fastrange product: 32-bit upper hash times block count
    localparam int FR_PROD_W = WORD_W + CFG_W;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef logic [WORDS-1:0][POS_W-1:0] pos_vec_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } back_state_t;

    localparam logic [WORD_W-1:0] SALTS [WORDS] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    // one set bit per 32-bit word at the given positions
    function automatic logic [BLOCK_W-1:0] build_mask(pos_vec_t pos);
        logic [BLOCK_W-1:0] m;
        m = '0;
        for (int w = 0; w < WORDS; w++)
        begin
            m[w*WORD_W + int'(pos[w])] = 1'b1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/sbbf_front.sv */
// ----------------------------------------------------------------------------
// sbbf_front
// Accepts hash beats, computes the fastrange block index and the eight bit
// positions, and holds the classified item in one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_front #(
    parameter int MAX_BLOCKS = sbbf_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [sbbf_pkg::CFG_W-1:0]  blocks_in_use,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_cmd,
    input  wire logic [63:0]                 in_hash,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output sbbf_pkg::cmd_t                   out_cmd,
    output logic [IDX_W-1:0]                 out_idx,
    output sbbf_pkg::pos_vec_t               out_pos
);

    logic                          valid_reg, valid_next;
    sbbf_pkg::cmd_t                cmd_reg;
    logic [IDX_W-1:0]              idx_reg;
    sbbf_pkg::pos_vec_t            pos_reg;

    logic                          accept;
    logic [sbbf_pkg::CFG_W-1:0]    eff_blocks;
    logic [sbbf_pkg::FR_PROD_W-1:0] fr_prod;
    logic [IDX_W-1:0]              idx_calc;
    sbbf_pkg::pos_vec_t            pos_calc;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // block count clamped to 1..MAX_BLOCKS
    always_comb
    begin
        eff_blocks = blocks_in_use;
        if (blocks_in_use == '0)
        begin
            eff_blocks = sbbf_pkg::CFG_W'(1);
        end
        else if (32'(blocks_in_use) > 32'(MAX_BLOCKS))
        begin
            eff_blocks = sbbf_pkg::CFG_W'(MAX_BLOCKS);
        end
    end

    // fastrange index: (upper * blocks) >> 32
    assign fr_prod  = sbbf_pkg::FR_PROD_W'(in_hash[63:32])
                    * sbbf_pkg::FR_PROD_W'(eff_blocks);
    assign idx_calc = IDX_W'(fr_prod[sbbf_pkg::FR_PROD_W-1:sbbf_pkg::WORD_W]);

    // salted key products, top five bits pick the bit in each word
    always_comb
    begin
        logic [sbbf_pkg::WORD_W-1:0] prod;
        prod = '0;
        for (int w = 0; w < sbbf_pkg::WORDS; w++)
        begin
            prod        = in_hash[31:0] * sbbf_pkg::SALTS[w];
            pos_calc[w] = prod[sbbf_pkg::POS_SHIFT +: sbbf_pkg::POS_W];
        end
    end

    // stage valid
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= sbbf_pkg::cmd_t'(in_cmd);
            idx_reg <= idx_calc;
            pos_reg <= pos_calc;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_idx   = idx_reg;
    assign out_pos   = pos_reg;

endmodule

`default_nettype wire

/* sv/sbbf_queue.sv */
// ----------------------------------------------------------------------------
// sbbf_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = sbbf_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output logic [DATA_W-1:0]      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slots[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* sv/sbbf_back.sv */
// ----------------------------------------------------------------------------
// sbbf_back
// Owns the block store: clears it after reset, then performs each queued
// insert (read-modify-write) or query (read and compare) in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbf_back #(
    parameter int MAX_BLOCKS = sbbf_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    output logic                     clearing,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire sbbf_pkg::cmd_t      q_cmd,
    input  wire logic [IDX_W-1:0]    q_idx,
    input  wire sbbf_pkg::pos_vec_t  q_pos,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic                     res_hit
);

    sbbf_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg;

    sbbf_pkg::cmd_t        cur_cmd_reg;
    logic [IDX_W-1:0]      cur_idx_reg;
    sbbf_pkg::pos_vec_t    cur_pos_reg;

    logic [sbbf_pkg::BLOCK_W-1:0] store [MAX_BLOCKS];
    logic [sbbf_pkg::BLOCK_W-1:0] rd_data_reg;

    logic                         mem_we, mem_re, out_load;
    logic [IDX_W-1:0]             mem_waddr;
    logic [sbbf_pkg::BLOCK_W-1:0] mem_wdata;
    logic [sbbf_pkg::BLOCK_W-1:0] mask;
    logic                         hit;

    assign mask = sbbf_pkg::build_mask(cur_pos_reg);
    assign hit  = ((rd_data_reg & mask) == mask);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = cur_idx_reg;
        mem_wdata    = rd_data_reg | mask;
        q_ready      = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            sbbf_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    state_next = sbbf_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            sbbf_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready    = 1'b1;
                    mem_re     = 1'b1;
                    state_next = sbbf_pkg::ST_EXEC;
                end
            end
            sbbf_pkg::ST_EXEC:
            begin
                if (cur_cmd_reg == sbbf_pkg::CMD_INSERT)
                begin
                    mem_we     = 1'b1;
                    state_next = sbbf_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || res_ready)
                begin
                    out_load   = 1'b1;
                    state_next = sbbf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbbf_pkg::ST_CLEAR;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbbf_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // current item and result payload
    always_ff @(posedge clk)
    begin
        if (q_ready)
        begin
            cur_cmd_reg <= q_cmd;
            cur_idx_reg <= q_idx;
            cur_pos_reg <= q_pos;
        end
        if (out_load)
        begin
            out_hit_reg <= hit;
        end
    end

    // block store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store[q_idx];
        end
    end

    assign clearing  = (state_reg == sbbf_pkg::ST_CLEAR);
    assign res_valid = out_valid_reg;
    assign res_hit   = out_hit_reg;

endmodule

`default_nettype wire

/* sv/split_block_bloom_filter.sv */
// ----------------------------------------------------------------------------
// split_block_bloom_filter
// Split block Bloom filter over MAX_BLOCKS blocks of 256 bits, with insert
// and query commands and an APB register for the number of blocks in use.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries the 64-bit hash, s_tuser the command (0 insert, 1 query).
//   An insert sets eight bits in the selected block and returns nothing; a
//   query returns one beat on m_tdata bit 0: 1 maybe present, 0 absent.
//   blocks_in_use (APB address 0) selects how many blocks the index spans;
//   0 acts as 1 and values above MAX_BLOCKS act as MAX_BLOCKS. Write it only
//   while no item is in flight; the store is not cleared by a write.
//   Path: a query passes the front stage, the queue, the block read and the
//   compare, then its result appears on m_tvalid.
//   Items: the back end finishes each item, a block read and for an insert
//   a write back, before it takes the next one from the queue.
//   Reset: after rst_n is released the store is cleared one block a cycle,
//   one pass over all MAX_BLOCKS blocks; s_tready stays low meanwhile.
//   Stall: when m_tready is low the result waits in the output register,
//   the queue keeps taking items until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module split_block_bloom_filter #(
    parameter int MAX_BLOCKS = sbbf_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input beats
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [63:0]                     s_tdata,   // [63:0] hash_value
    input  wire logic                            s_tuser,   // [0] cmd
    // result beats
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [7:0]                           m_tdata,   // [0] may_contain
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sbbf_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sbbf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sbbf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENTRY_W = 1 + sbbf_pkg::WORDS * sbbf_pkg::POS_W + IDX_W;

    logic [sbbf_pkg::CFG_W-1:0] blocks_reg, blocks_next;
    logic                       cfg_wr;

    logic                       fr_ready, fr_valid, q_in_ready;
    sbbf_pkg::cmd_t             fr_cmd;
    logic [IDX_W-1:0]           fr_idx;
    sbbf_pkg::pos_vec_t         fr_pos;

    logic [ENTRY_W-1:0]         q_wr_data, q_rd_data;
    logic                       q_valid, q_ready;
    logic                       clearing;
    logic                       res_hit;

    // register write and read
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == sbbf_pkg::REG_BLOCKS_IN_USE);

    always_comb
    begin
        blocks_next = blocks_reg;
        if (cfg_wr)
        begin
            blocks_next = pwdata[sbbf_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= sbbf_pkg::BLOCKS_RESET;
        end
        else
        begin
            blocks_reg <= blocks_next;
        end
    end

    assign prdata = (paddr[2] == sbbf_pkg::REG_BLOCKS_IN_USE)
                  ? sbbf_pkg::APB_DATA_W'(blocks_reg) : '0;

    // front end
    assign s_tready = fr_ready && !clearing;

    sbbf_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .blocks_in_use (blocks_reg),
        .in_valid      (s_tvalid && !clearing),
        .in_ready      (fr_ready),
        .in_cmd        (s_tuser),
        .in_hash       (s_tdata),
        .out_valid     (fr_valid),
        .out_ready     (q_in_ready),
        .out_cmd       (fr_cmd),
        .out_idx       (fr_idx),
        .out_pos       (fr_pos)
    );

    // decoupling queue
    assign q_wr_data = {fr_cmd, fr_pos, fr_idx};

    sbbf_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (sbbf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd_data)
    );

    // back end
    sbbf_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (sbbf_pkg::cmd_t'(q_rd_data[ENTRY_W-1])),
        .q_idx     (q_rd_data[IDX_W-1:0]),
        .q_pos     (sbbf_pkg::pos_vec_t'(q_rd_data[ENTRY_W-2:IDX_W])),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_hit   (res_hit)
    );

    assign m_tdata = {7'b0, res_hit};

    // back end never pops an empty queue
    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> q_valid)
        else $error("back end popped an empty queue");

    // no queue traffic to the back end while the store is being cleared
    a_no_pop_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_ready)
        else $error("item taken during clearing pass");

    // no result can exist before the clearing pass has finished
    a_no_result_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !m_tvalid)
        else $error("result valid during clearing pass");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the split block Bloom filter against a shadow copy of its block
// store. Inserts and queries go in on the input stream, and query answers
// are compared in order with predicted ones. A short table of directed beats
// and register writes comes first. Random phases follow, each with its own
// block count and a chosen mix of sender gaps and receiver stalls. One phase
// holds the receiver off long enough for the input to back up.
// ----------------------------------------------------------------------------

module testbench;

    localparam int MAX_BLOCKS     = sbbf_pkg::MAX_BLOCKS_DEF;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_BEATS    = 118;
    localparam int RECENT_DEPTH   = 64;

    // byte addresses on the register port
    localparam logic [sbbf_pkg::APB_ADDR_W-1:0] ADDR_BLOCKS =
        {sbbf_pkg::REG_BLOCKS_IN_USE, 2'b00};
    localparam logic [sbbf_pkg::APB_ADDR_W-1:0] ADDR_NO_REG =
        {~sbbf_pkg::REG_BLOCKS_IN_USE, 2'b00};

    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        sbbf_pkg::cmd_t                  cmd;
        logic [63:0]                     word;      // hash for a beat, data for a write
        logic [sbbf_pkg::APB_ADDR_W-1:0] addr;
        logic                            typed;     // answer given in the row
        logic                            typed_hit;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [63:0]                     s_tdata;   // [63:0] hash_value
    logic                            s_tuser;   // [0] cmd
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;   // [0] may_contain
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [sbbf_pkg::APB_ADDR_W-1:0] paddr;
    logic [sbbf_pkg::APB_DATA_W-1:0] pwdata;
    logic [sbbf_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // shadow of the block store and of the block count register
    bit [sbbf_pkg::BLOCK_W-1:0] shadow_store [MAX_BLOCKS];
    bit [sbbf_pkg::CFG_W-1:0]   shadow_blocks = sbbf_pkg::BLOCKS_RESET;

    // answers still owed by the block, oldest first
    bit               pending_answers [$];
    bit [63:0]        recent_inserts [$];

    bit               tx_idle;
    bit               rx_idle;
    int               hold_asked;
    int               hold_served;

    int               err_count;
    int               insert_count;
    int               query_count;
    int               present_count;
    int               absent_count;
    int               cfg_writes;
    int               stall_cycles;
    int               quiet_cycles;

    dir_row_t         dir_rows [24];
    int unsigned      phase_blocks [PHASES] = '{1, 2047, 0, 5, 1000, 333, 2, 1024};
    bit               phase_tx_idle [PHASES] = '{1, 1, 1, 0, 0, 1, 1, 0};
    bit               phase_rx_idle [PHASES] = '{1, 1, 0, 1, 0, 1, 1, 0};

    split_block_bloom_filter #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // eight bit positions from the key, one per 32-bit word
    function automatic bit [sbbf_pkg::BLOCK_W-1:0] probe_mask(input bit [31:0] key);
        bit [sbbf_pkg::BLOCK_W-1:0] m;
        bit [31:0]                  prod;
        m = '0;
        for (int w = 0; w < sbbf_pkg::WORDS; w++)
        begin
            prod = key * sbbf_pkg::SALTS[w];
            m[w*sbbf_pkg::WORD_W + int'(prod >> sbbf_pkg::POS_SHIFT)] = 1'b1;
        end
        return m;
    endfunction

    // apply one beat to the shadow store, return the query answer
    function automatic bit probe_filter(input sbbf_pkg::cmd_t c, input bit [63:0] h);
        int unsigned                span;
        bit [63:0]                  prod;
        int unsigned                idx;
        bit [sbbf_pkg::BLOCK_W-1:0] m;
        span = shadow_blocks;
        if (span == 0)
            span = 1;
        if (span > MAX_BLOCKS)
            span = MAX_BLOCKS;
        prod = {32'b0, h[63:32]} * 64'(span);
        idx  = prod[63:32];
        if (idx >= MAX_BLOCKS)
            idx = MAX_BLOCKS - 1;
        m = probe_mask(h[31:0]);
        if (c == sbbf_pkg::CMD_INSERT)
        begin
            shadow_store[idx] |= m;
            return 1'b0;
        end
        return (shadow_store[idx] & m) == m;
    endfunction

    // offer one beat, wait for it to be taken, record the owed answer
    task automatic send_beat(input sbbf_pkg::cmd_t c, input bit [63:0] h,
                             input bit typed, input bit typed_hit);
        bit answer;
        if (tx_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = h;
        s_tuser  = c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        answer = probe_filter(c, h);
        if (c == sbbf_pkg::CMD_QUERY)
        begin
            pending_answers.push_back(typed ? typed_hit : answer);
            query_count++;
        end
        else
        begin
            recent_inserts.push_back(h);
            if (recent_inserts.size() > RECENT_DEPTH)
                void'(recent_inserts.pop_front());
            insert_count++;
        end
        @(negedge clk);
    endtask

    // read the block count back and compare with the shadow
    task automatic check_blocks_reg();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_BLOCKS;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== sbbf_pkg::APB_DATA_W'(shadow_blocks))
        begin
            $error("blocks_in_use mismatch: expected %0d, got %0d",
                   shadow_blocks, prdata);
            err_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // let the block go quiet, write a register, read the count back
    task automatic set_register(input logic [sbbf_pkg::APB_ADDR_W-1:0] addr,
                                input bit [31:0] value);
        s_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr[2] == sbbf_pkg::REG_BLOCKS_IN_USE)
            shadow_blocks = value[sbbf_pkg::CFG_W-1:0];
        cfg_writes++;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_blocks_reg();
    endtask

    // receiver: random stall bursts, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_served)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served++;
                m_tready = 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_tready = 1'b1;
            end
            else
                m_tready = 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("may_contain: result beat with no query waiting, got %0d",
                       m_tdata[0]);
                err_count++;
            end
            else if (m_tdata[0] !== pending_answers[0])
            begin
                $error("may_contain mismatch: expected %0d, got %0d",
                       pending_answers[0], m_tdata[0]);
                err_count++;
                void'(pending_answers.pop_front());
            end
            else
                void'(pending_answers.pop_front());
            if (m_tdata[0] === 1'b1)
                present_count++;
            else
                absent_count++;
        end
        if (rst_n && s_tvalid && !s_tready)
            stall_cycles++;
    end

    // watchdog on cycles with no beat taken on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no beat taken for %0d cycles", quiet_cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int             r;
        sbbf_pkg::cmd_t c;
        bit [63:0]      h;
        bit [31:0]      wval;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sbbf_pkg::CMD_INSERT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;

        // directed beats and register writes
        dir_rows = '{
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h0000_0000_0000_0000, ADDR_BLOCKS, 1'b1, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, ADDR_BLOCKS, 1'b1, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_INSERT, 64'h0000_0000_0000_0000, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h0000_0000_0000_0000, ADDR_BLOCKS, 1'b1, 1'b1},
            '{ROW_BEAT, sbbf_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, ADDR_BLOCKS, 1'b1, 1'b1},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h0000_0000_FFFF_FFFF, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'hFFFF_FFFF_0000_0000, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_INSERT, 64'h8000_0000_1234_5678, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h8000_0000_1234_5678, ADDR_BLOCKS, 1'b1, 1'b1},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h8000_0000_1234_5679, ADDR_BLOCKS, 1'b0, 1'b0},
            // zero count behaves as a single block
            '{ROW_WRITE, sbbf_pkg::CMD_INSERT, 64'd0, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'hFFFF_FFFF_0000_0000, ADDR_BLOCKS, 1'b1, 1'b1},
            '{ROW_BEAT, sbbf_pkg::CMD_INSERT, 64'hDEAD_BEEF_0BAD_F00D, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h0000_0001_0BAD_F00D, ADDR_BLOCKS, 1'b0, 1'b0},
            // count above the store saturates
            '{ROW_WRITE, sbbf_pkg::CMD_INSERT, 64'd2047, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, ADDR_BLOCKS, 1'b1, 1'b1},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h7FFF_FFFF_0000_0000, ADDR_BLOCKS, 1'b0, 1'b0},
            // write to an unused address leaves the count alone
            '{ROW_WRITE, sbbf_pkg::CMD_INSERT, 64'd1, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_WRITE, sbbf_pkg::CMD_INSERT, 64'd7, ADDR_NO_REG, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h9ABC_DEF0_0000_0000, ADDR_BLOCKS, 1'b1, 1'b1},
            // upper data bits are dropped, count goes back to 1024
            '{ROW_WRITE, sbbf_pkg::CMD_INSERT, 64'hFFFF_FC00, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_INSERT, 64'h0000_0000_0000_0001, ADDR_BLOCKS, 1'b0, 1'b0},
            '{ROW_BEAT, sbbf_pkg::CMD_QUERY, 64'h0000_0000_0000_0001, ADDR_BLOCKS, 1'b1, 1'b1}
        };

        // reset once, then check the register's reset value
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        check_blocks_reg();

        // directed part
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                set_register(dir_rows[i].addr, dir_rows[i].word[31:0]);
            else
                send_beat(dir_rows[i].cmd, dir_rows[i].word,
                          dir_rows[i].typed, dir_rows[i].typed_hit);
        end

        // random phases, one block count each
        for (int p = 0; p < PHASES; p++)
        begin
            wval = ($urandom & 32'hFFFF_F800) | phase_blocks[p];
            set_register(ADDR_BLOCKS, wval);
            tx_idle = phase_tx_idle[p];
            rx_idle = phase_rx_idle[p];
            if (p == 1)
                hold_asked++;
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                r = $urandom_range(0, 19);
                c = ($urandom_range(0, 9) < 4) ? sbbf_pkg::CMD_INSERT : sbbf_pkg::CMD_QUERY;
                h = {$urandom, $urandom};
                if (r == 0)
                    h[63:32] = '0;
                else if (r == 1)
                    h[63:32] = '1;
                else if (c == sbbf_pkg::CMD_QUERY && recent_inserts.size() != 0)
                begin
                    // mostly ask for keys that went in, some one bit off
                    if (r < 10)
                        h = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
                    else if (r < 13)
                        h = recent_inserts[recent_inserts.size() - 1];
                    else if (r < 15)
                        h = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)]
                            ^ (64'd1 << $urandom_range(0, 31));
                end
                send_beat(c, h, 1'b0, 1'b0);
            end
        end

        // drain and let the pipeline settle
        s_tvalid = 1'b0;
        while (pending_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d inserts and %0d queries (%0d hits, %0d misses)",
                 insert_count, query_count, present_count, absent_count);
        $display("over %0d register writes; input held back on %0d cycles",
                 cfg_writes, stall_cycles);
        if (err_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/sbbf_pkg.sv
sv/sbbf_front.sv
sv/sbbf_queue.sv
sv/sbbf_back.sv
sv/split_block_bloom_filter.sv
tb/testbench.sv
